FILE: sv/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; included by the controller, datapath and top level.
`default_nettype none
package spq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int PRI_W = 8;
  localparam int OCNT_W = 4;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    MODE_ENQ = 1'b0,
    MODE_DEQ = 1'b1
  } mode_t;

  typedef enum logic {
    CTL_IDLE   = 1'b0,
    CTL_RESULT = 1'b1
  } ctl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic    load;    // capture a new result
    logic    enq;     // insert the request entry
    logic    deq;     // remove the head entry
    status_t status;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/spq_ctrl.sv
// Handshake controller for the sorted priority queue.
// Depends on spq_pkg; drives commands into spq_datapath.
`default_nettype none
module spq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic              mode,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire spq_pkg::dp_stat_t dp_stat,
  output spq_pkg::dp_cmd_t       dp_cmd
);
  import spq_pkg::*;

  ctl_state_t state, state_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      CTL_IDLE: begin
        s_tready = 1'b1;
      end
      CTL_RESULT: begin
        m_tvalid = 1'b1;
        // free the result register as it is taken
        s_tready = m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
    accept = s_tvalid && s_tready;
    if (accept) begin
      state_next = CTL_RESULT;
    end else if (state == CTL_RESULT && m_tready) begin
      state_next = CTL_IDLE;
    end
  end

  always_comb begin
    dp_cmd        = '0;
    dp_cmd.status = STAT_OK;
    dp_cmd.load   = accept;
    if (mode == MODE_ENQ) begin
      if (dp_stat.full) begin
        dp_cmd.status = STAT_FULL;
      end else begin
        dp_cmd.enq = accept;
      end
    end else begin
      if (dp_stat.empty) begin
        dp_cmd.status = STAT_EMPTY;
      end else begin
        dp_cmd.deq = accept;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/spq_datapath.sv
// Sorted shift-register cells, entry count and result register.
// Depends on spq_pkg; commanded by spq_ctrl.
`default_nettype none
module spq_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire spq_pkg::dp_cmd_t              dp_cmd,
  output spq_pkg::dp_stat_t                  dp_stat,
  input  wire logic signed [spq_pkg::VAL_W-1:0] value,
  input  wire logic [spq_pkg::PRI_W-1:0]     priority_req,
  output logic signed [spq_pkg::VAL_W-1:0]   value_out,
  output logic [1:0]                         status,
  output logic [spq_pkg::OCNT_W-1:0]         count_out
);
  import spq_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic signed [VAL_W-1:0] val_q [DEPTH];
  logic [PRI_W-1:0]        pri_q [DEPTH];
  logic [CNT_W-1:0]        count;
  logic [DEPTH-1:0]        ge;
  logic [CNT_W+OCNT_W-1:0] count_ext;

  assign dp_stat.full  = (count == FULL_CNT);
  assign dp_stat.empty = (count == '0);

  // Cells holding priority >= the request form a prefix of the sorted array.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ge[i] = (CNT_W'(i) < count) && (pri_q[i] >= priority_req);

    always_ff @(posedge clk) begin
      if (dp_cmd.enq) begin
        if (!ge[i]) begin
          if (i == 0) begin
            val_q[i] <= value;
            pri_q[i] <= priority_req;
          end else if (ge[(i > 0) ? i - 1 : 0]) begin
            val_q[i] <= value;
            pri_q[i] <= priority_req;
          end else begin
            // make room: take the entry from the cell ahead
            val_q[i] <= val_q[(i > 0) ? i - 1 : 0];
            pri_q[i] <= pri_q[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (dp_cmd.deq && i < DEPTH - 1) begin
        // advance every entry toward the head
        val_q[i] <= val_q[(i < DEPTH - 1) ? i + 1 : i];
        pri_q[i] <= pri_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.enq) begin
      count <= count + CNT_W'(1);
    end else if (dp_cmd.deq) begin
      count <= count - CNT_W'(1);
    end
  end

  assign count_ext = {{OCNT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      value_out <= dp_cmd.deq ? val_q[0] : '0;
      status    <= dp_cmd.status;
      if (dp_cmd.enq) begin
        count_out <= OCNT_W'(count_ext + (CNT_W + OCNT_W)'(1));
      end else if (dp_cmd.deq) begin
        count_out <= OCNT_W'(count_ext - (CNT_W + OCNT_W)'(1));
      end else begin
        count_out <= count_ext[OCNT_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: stream ports, controller and datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
`default_nettype none
// Bounded priority queue of DEPTH entries kept sorted highest priority first in a
// row of shift cells. Each request (s_tuser 0 enqueue, 1 dequeue) gives one result.
// An enqueue lands behind all entries of greater or equal priority; a full queue
// refuses it with status 1, an empty queue refuses a dequeue with status 2.
// All cells compare against the new priority in parallel and shift in the same cycle
// that the request is accepted. A new request is taken while the previous result is
// being transferred, so one request per cycle is sustained while m_tready is high.
module sorted_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // [31:0] value, [39:32] priority_req
  input  wire logic        s_tuser,  // [0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // [31:0] value_out, [35:32] count_out, rest zero
  output logic [1:0]       m_tuser   // [1:0] status
);
  import spq_pkg::*;

  dp_cmd_t                 dp_cmd;
  dp_stat_t                dp_stat;
  logic signed [VAL_W-1:0] value_out;
  logic [OCNT_W-1:0]       count_out;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  spq_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .dp_stat      (dp_stat),
    .value        (s_tdata[31:0]),
    .priority_req (s_tdata[39:32]),
    .value_out    (value_out),
    .status       (m_tuser),
    .count_out    (count_out)
  );

  assign m_tdata = {4'b0000, count_out, value_out};

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for sorted_priority_queue: enqueue/dequeue requests on the
// input stream, results predicted by a priority-ordered queue model and compared per field.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb_top;
  import spq_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 80;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    status_t          status;
    logic [3:0]       count;
  } queue_result_t;

  // Tracks queue contents and the results still owed by the block.
  class queue_scoreboard;
    logic [VAL_W-1:0] val_slot[DEPTH];
    logic [PRI_W-1:0] pri_slot[DEPTH];
    int unsigned      fill;
    queue_result_t    owed_q[$];
    int               errors;
    int               n_enq, n_full, n_deq, n_empty;

    function new();
      fill = 0;
      errors = 0;
      n_enq = 0;
      n_full = 0;
      n_deq = 0;
      n_empty = 0;
    endfunction

    function void note_request(mode_t mode, logic [VAL_W-1:0] value,
                               logic [PRI_W-1:0] prio);
      queue_result_t res;
      int unsigned   pos;
      res.value = '0;
      res.status = STAT_OK;
      if (mode == MODE_ENQ) begin
        if (fill >= DEPTH) begin
          res.status = STAT_FULL;
          n_full++;
        end else begin
          // shift lower-priority entries back; ties stay ahead of the newcomer
          pos = fill;
          while (pos > 0 && pri_slot[pos-1] < prio) begin
            val_slot[pos] = val_slot[pos-1];
            pri_slot[pos] = pri_slot[pos-1];
            pos--;
          end
          val_slot[pos] = value;
          pri_slot[pos] = prio;
          fill++;
          n_enq++;
        end
      end else begin
        if (fill == 0) begin
          res.status = STAT_EMPTY;
          n_empty++;
        end else begin
          res.value = val_slot[0];
          for (int k = 1; k < fill; k++) begin
            val_slot[k-1] = val_slot[k];
            pri_slot[k-1] = pri_slot[k];
          end
          fill--;
          n_deq++;
        end
      end
      res.count = fill[3:0];
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [39:0] data, logic [1:0] user);
      queue_result_t exp_res;
      if (owed_q.size() == 0) begin
        $error("unexpected result: value_out %0d, status %0d", $signed(data[31:0]), user);
        errors++;
        return;
      end
      exp_res = owed_q.pop_front();
      if (data[31:0] !== exp_res.value) begin
        $error("value_out mismatch: expected %0d, actual %0d",
               $signed(exp_res.value), $signed(data[31:0]));
        errors++;
      end
      if (data[35:32] !== exp_res.count) begin
        $error("count_out mismatch: expected %0d, actual %0d", exp_res.count, data[35:32]);
        errors++;
      end
      if (data[39:36] !== 4'd0) begin
        $error("tdata padding mismatch: expected 0, actual %0h", data[39:36]);
        errors++;
      end
      if (user !== exp_res.status) begin
        $error("status mismatch: expected %0d, actual %0d", exp_res.status, user);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  queue_scoreboard sb;
  int              requests_taken;
  int              idle_cycles;
  bit              holdoff_done;

  sorted_priority_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),  // [31:0] value, [39:32] priority_req
    .s_tuser  (s_tuser),  // [0] mode
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),  // [31:0] value_out, [35:32] count_out
    .m_tuser  (m_tuser)   // [1:0] status
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Called at a falling edge; returns at the falling edge after the transfer.
  task send_request(input mode_t mode, input logic [VAL_W-1:0] value,
                    input logic [PRI_W-1:0] prio);
    s_tuser = mode;
    s_tdata = {prio, value};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(mode, value, prio);
    requests_taken++;
    @(negedge clk);
  endtask

  // Result side: random ready pattern, plus one long hold-off to back up the input.
  initial begin
    int pat_left;
    int pat_kind;
    pat_left = 0;
    pat_kind = 0;
    holdoff_done = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && !holdoff_done && requests_taken >= 300) begin
        m_tready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_done = 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_kind = $urandom_range(2);
          pat_left = $urandom_range(10, 60);
        end
        pat_left--;
        case (pat_kind)
          0: m_tready = 1'b1;
          1: m_tready = ($urandom_range(3) != 0);
          default: m_tready = ($urandom_range(3) == 0);
        endcase
      end
    end
  end

  // Check every result transfer and watch for a stuck handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("no transfer for %0d cycles, giving up", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [VAL_W-1:0] dir_val[8];
    logic [PRI_W-1:0] dir_pri[8];
    int               burst_left;
    int               bias;
    int               bias_left;
    mode_t            mode;
    logic [VAL_W-1:0] value;
    logic [PRI_W-1:0] prio;

    dir_val = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                32'h0000_0001, 32'h55AA_55AA, 32'hAA55_AA55, 32'h1234_5678};
    dir_pri = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd128, 8'd1, 8'd254};
    sb = new();
    requests_taken = 0;
    idle_cycles = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = MODE_ENQ;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty dequeue, fill with extremes and ties, full refusal, drain past empty.
    send_request(MODE_DEQ, 32'hDEAD_BEEF, 8'hFF);
    for (int i = 0; i < 8; i++) send_request(MODE_ENQ, dir_val[i], dir_pri[i]);
    send_request(MODE_ENQ, 32'h0BAD_F00D, 8'd255);
    for (int i = 0; i < 9; i++) send_request(MODE_DEQ, '0, '0);

    // Random: bursty sender, enqueue bias drifts so the queue swings between empty and full.
    burst_left = 0;
    bias = 50;
    bias_left = 0;
    for (int i = 0; i < 1600; i++) begin
      if (bias_left == 0) begin
        case ($urandom_range(2))
          0: bias = 20;
          1: bias = 50;
          default: bias = 85;
        endcase
        bias_left = $urandom_range(20, 120);
      end
      bias_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(3) != 0) begin
          s_tvalid = 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk);
        end
      end
      burst_left--;
      mode = ($urandom_range(99) < bias) ? MODE_ENQ : MODE_DEQ;
      value = $urandom;
      if ($urandom_range(15) == 0) value = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      // narrow priorities give plenty of ties
      prio = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
      send_request(mode, value, prio);
    end
    s_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d requests: %0d enqueued, %0d refused full, %0d dequeued, %0d refused empty",
             requests_taken, sb.n_enq, sb.n_full, sb.n_deq, sb.n_empty);
    $display("ready hold-off of %0d cycles applied: %0d", HOLDOFF_CYCLES, holdoff_done);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
